// ===== hdl/bha_pkg.sv =====
// ----------------------------------------------------------------------------
// bha_pkg
// Shared types, widths and helpers for the bitmap handle allocator.
// ----------------------------------------------------------------------------
package bha_pkg;

  // slot groups, each tracked by one 64-bit free mask
  localparam int GROUPS   = 16;
  localparam int GROUP_W  = $clog2(GROUPS);
  localparam int SLOT_W   = 6;
  localparam int SLOTS    = 1 << SLOT_W;
  localparam int BYTE_W   = SLOT_W - 3;
  localparam int HANDLE_W = 11;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // stream word widths, rounded up to whole bytes
  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 8;
  localparam int M_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef logic [SLOTS-1:0] mask_t;

  // position of the lowest set bit of one byte
  function automatic logic [2:0] lowest_in_byte(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) pos = 3'(i);
    end
    return pos;
  endfunction

endpackage

// ===== hdl/bitmap_handle_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_handle_allocator_core
// Allocates, frees and checks handles over groups of 64 slots, one free
// mask per group held in a small memory with a byte-wide slot search unit.
// ----------------------------------------------------------------------------
// Sequence: free, query, no-op and a full allocate pass through the read and
//   finish states; an allocate that finds a free group also passes through
//   the scan state, where the search unit examines mask bytes in turn (up to 8).
// Throughput: one word at a time; the next word is taken the cycle after
//   the result is registered, set by the mask memory read and the search unit.
// Reset: asynchronous, active low; every slot reads as free after reset
//   through per-group written bits, so no clearing pass is needed.
module bitmap_handle_allocator_core
  import bha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // [10:0] handle
  input  logic [S_USER_W-1:0] s_axis_tuser,   // [1:0] cmd
  // result words
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata    // [10:0] out_handle, [12:11] status,
                                              // [13] is_live
);

  localparam int GFIELD_W = HANDLE_W - SLOT_W;

  state_e state_q, state_d;

  // latched command
  cmd_e                cmd_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [GROUP_W-1:0]  grp_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                in_range_q;
  logic                found_q;
  logic [BYTE_W-1:0]   byte_q;

  // mask memory, written bits and per-group non-full flags
  mask_t               mem [GROUPS];
  mask_t               rd_q;
  logic                rd_vld_q;
  logic [GROUPS-1:0]   written_q;
  logic [GROUPS-1:0]   nonfull_q;

  // output register
  logic                out_valid_q;
  logic [HANDLE_W-1:0] out_handle_q;
  status_e             status_q;
  logic                live_q;

  logic                accept;
  logic                load;
  logic                mem_we;
  mask_t               word;
  mask_t               new_word;
  logic [7:0]          chunk;
  logic                slot_used;

  cmd_e                in_cmd;
  logic [HANDLE_W-1:0] in_handle;
  logic [HANDLE_W-1:0] in_id;
  logic [GFIELD_W-1:0] in_gfield;
  logic [GROUP_W-1:0]  alloc_grp;

  status_e             res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_live;

  assign in_cmd    = cmd_e'(s_axis_tuser[CMD_W-1:0]);
  assign in_handle = s_axis_tdata[HANDLE_W-1:0];
  assign in_id     = in_handle - HANDLE_W'(1);
  assign in_gfield = in_id[HANDLE_W-1:SLOT_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);

  // lowest group that still has a free slot
  always_comb begin
    alloc_grp = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (nonfull_q[i]) alloc_grp = GROUP_W'(i);
    end
  end

  // mask word as read, unwritten groups are all free
  assign word      = rd_vld_q ? rd_q : '1;
  assign chunk     = word[{byte_q, 3'b000} +: 8];
  assign slot_used = !word[slot_q];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_READ;
      ST_READ:   state_d = (cmd_q == CMD_ALLOC && found_q) ? ST_SCAN : ST_FINISH;
      ST_SCAN:   if (chunk != 8'd0) state_d = ST_FINISH;
      ST_FINISH: if (load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // result and mask update
  always_comb begin
    res_handle = handle_q;
    res_status = STATUS_OK;
    res_live   = 1'b0;
    new_word   = word;
    mem_we     = 1'b0;
    case (cmd_q)
      CMD_ALLOC: begin
        res_handle = '0;
        if (found_q) begin
          new_word   = word & ~(mask_t'(1) << slot_q);
          mem_we     = load;
          res_handle = HANDLE_W'({grp_q, slot_q}) + HANDLE_W'(1);
        end else begin
          res_status = STATUS_FULL;
        end
      end
      CMD_FREE: begin
        if (handle_q != '0) begin
          if (in_range_q && slot_used) begin
            new_word = word | (mask_t'(1) << slot_q);
            mem_we   = load;
          end else begin
            res_status = STATUS_INVALID;
          end
        end
      end
      CMD_QUERY: begin
        res_live = (handle_q == '0) || (in_range_q && slot_used);
      end
      default: begin
        res_live = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      written_q   <= '0;
      nonfull_q   <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        written_q[grp_q] <= 1'b1;
        nonfull_q[grp_q] <= (new_word != '0);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command capture and slot search unit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= in_cmd;
      handle_q   <= in_handle;
      found_q    <= (nonfull_q != '0);
      byte_q     <= '0;
      in_range_q <= (int'(in_gfield) < GROUPS);
      if (in_cmd == CMD_ALLOC) begin
        grp_q  <= alloc_grp;
        slot_q <= '0;
      end else begin
        grp_q  <= in_gfield[GROUP_W-1:0];
        slot_q <= in_id[SLOT_W-1:0];
      end
    end else if (state_q == ST_SCAN) begin
      if (chunk != 8'd0) begin
        slot_q <= {byte_q, lowest_in_byte(chunk)};
      end else begin
        byte_q <= byte_q + BYTE_W'(1);
      end
    end
  end

  // mask memory
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_q     <= mem[grp_q];
      rd_vld_q <= written_q[grp_q];
    end
    if (mem_we) begin
      mem[grp_q] <= new_word;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_handle_q <= res_handle;
      status_q     <= res_status;
      live_q       <= res_live;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, live_q, status_q, out_handle_q};

`ifndef SYNTHESIS
  // the non-full flag follows the mask that was written
  a_nonfull_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> nonfull_q[$past(grp_q)] == ($past(new_word) != '0))
    else $error("non-full flag out of step with mask");

  // the slot search only runs on a group that has a free slot
  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && chunk == 8'd0) |-> (byte_q != '1))
    else $error("slot search ran past the last mask byte");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten");

  // an allocate that reports full saw no free group
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cmd_q == CMD_ALLOC && !found_q) |-> (nonfull_q == '0))
    else $error("full reported while a group has a free slot");
`endif

endmodule

// ===== verif/bitmap_handle_allocator_core_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_handle_allocator_core_check
// Watches both streams of the handle allocator. It keeps its own copy of the
// per-group free masks, works out the reply to every accepted command word
// and compares each result word, field by field, with the oldest reply due.
// ----------------------------------------------------------------------------
module bitmap_handle_allocator_core_check
  import bha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // [10:0] handle
  input  logic [S_USER_W-1:0] s_axis_tuser,   // [1:0] cmd
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [M_DATA_W-1:0] m_axis_tdata,   // [10:0] out_handle, [12:11] status,
                                              // [13] is_live
  output int unsigned         err_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    status_e             status;
    logic                live;
  } reply_t;

  mask_t       free_mask [GROUPS];
  reply_t      replies_due [$];
  int unsigned err_count = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // reply to one command word, updating the free masks
  function automatic reply_t allocator_step(input cmd_e op, input logic [HANDLE_W-1:0] h);
    reply_t              r;
    logic [HANDLE_W-1:0] id;
    logic [HANDLE_W-1:0] grp;
    logic [SLOT_W-1:0]   slot;
    logic                used;
    logic                found;
    r.handle = h;
    r.status = STATUS_OK;
    r.live   = 1'b0;
    id       = h - 1'b1;
    grp      = id >> SLOT_W;
    slot     = id[SLOT_W-1:0];
    used     = 1'b0;
    if (grp < GROUPS) begin
      used = !free_mask[grp[GROUP_W-1:0]][slot];
    end
    case (op)
      CMD_ALLOC: begin
        // lowest group with a free slot, then lowest free slot in it
        r.handle = '0;
        found    = 1'b0;
        for (int g = 0; g < GROUPS; g++) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!found && free_mask[g][s]) begin
              found            = 1'b1;
              free_mask[g][s]  = 1'b0;
              r.handle         = HANDLE_W'(g * SLOTS + s + 1);
            end
          end
        end
        if (!found) begin
          r.status = STATUS_FULL;
        end
      end
      CMD_FREE: begin
        // null handle is ignored
        if (h != '0) begin
          if (used) begin
            free_mask[grp[GROUP_W-1:0]][slot] = 1'b1;
          end else begin
            r.status = STATUS_INVALID;
          end
        end
      end
      CMD_QUERY: begin
        r.live = (h == '0) || used;
      end
      default: ;
    endcase
    return r;
  endfunction

  // compare result words, then record the reply to a new command word
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      for (int g = 0; g < GROUPS; g++) begin
        free_mask[g] = '1;
      end
      replies_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected result word", m_axis_tdata, 0);
        end else begin
          want = replies_due.pop_front();
          if (m_axis_tdata[HANDLE_W-1:0] !== want.handle) begin
            report_mismatch("out_handle", m_axis_tdata[HANDLE_W-1:0], want.handle);
          end
          if (m_axis_tdata[HANDLE_W+STATUS_W-1:HANDLE_W] !== want.status) begin
            report_mismatch("status", m_axis_tdata[HANDLE_W+STATUS_W-1:HANDLE_W],
                            want.status);
          end
          if (m_axis_tdata[HANDLE_W+STATUS_W] !== want.live) begin
            report_mismatch("is_live", m_axis_tdata[HANDLE_W+STATUS_W], want.live);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        replies_due.push_back(allocator_step(cmd_e'(s_axis_tuser[CMD_W-1:0]),
                                             s_axis_tdata[HANDLE_W-1:0]));
      end
    end
    pending_o   = replies_due.size();
    err_count_o = err_count;
  end

endmodule

// ===== verif/bitmap_handle_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_handle_allocator_core_tb
// Drives allocate, free, query and no-op words into the handle allocator:
// a directed opening, a run that fills every slot and runs into full, then
// random traffic in three idling phases, each with fewer frees. Results are
// checked beside it.
// ----------------------------------------------------------------------------
module bitmap_handle_allocator_core_tb
  import bha_pkg::*;
;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_WORDS    = 24;
  // one slot is still in use after the opening
  localparam int unsigned FILL_WORDS     = GROUPS * SLOTS + 3;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic [S_USER_W-1:0] s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;

  int unsigned err_count;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  logic        hold_req       = 1'b0;

  bitmap_handle_allocator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bitmap_handle_allocator_core_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one command word, idling first at the phase rate
  task automatic send_word(input cmd_e op, input logic [HANDLE_W-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'(h);
    s_axis_tuser  <= S_USER_W'(op);
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // stop offering until every reply has come back
  task automatic wait_replies();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // handles weighted toward the low groups where slots are in use
  function automatic logic [HANDLE_W-1:0] random_handle();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return HANDLE_W'($urandom_range(1, 160));
    if (pick < 75) return HANDLE_W'($urandom_range(1, GROUPS * SLOTS));
    if (pick < 83) return '0;
    if (pick < 92) return HANDLE_W'($urandom_range(0, GROUPS) * SLOTS + $urandom_range(0, 1));
    return HANDLE_W'($urandom_range(GROUPS * SLOTS + 1, (1 << HANDLE_W) - 1));
  endfunction

  task automatic send_random(input int unsigned free_pct);
    int unsigned pick;
    cmd_e        op;
    pick = $urandom_range(99);
    if (pick < free_pct) begin
      op = CMD_FREE;
    end else if (pick < free_pct + 15) begin
      op = CMD_QUERY;
    end else if (pick < free_pct + 19) begin
      op = CMD_NOP;
    end else begin
      op = CMD_ALLOC;
    end
    send_word(op, random_handle());
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed opening: null, unused, edge and out-of-range handles
    send_word(CMD_QUERY, 11'd0);
    send_word(CMD_FREE,  11'd0);
    send_word(CMD_FREE,  11'd1);
    send_word(CMD_FREE,  11'd1024);
    send_word(CMD_QUERY, 11'd1024);
    send_word(CMD_FREE,  11'd2047);
    send_word(CMD_QUERY, 11'd1025);
    send_word(CMD_ALLOC, 11'd2047);
    send_word(CMD_ALLOC, 11'd0);
    send_word(CMD_QUERY, 11'd1);
    send_word(CMD_FREE,  11'd1);
    send_word(CMD_QUERY, 11'd1);
    send_word(CMD_ALLOC, 11'h555);
    send_word(CMD_NOP,   11'h555);
    send_word(CMD_NOP,   11'h2aa);
    send_word(CMD_FREE,  11'd2);
    send_word(CMD_FREE,  11'd2);
    send_word(CMD_QUERY, 11'h7ff);
    wait_replies();

    // no idling: fill every slot and run into full, with one long hold-off
    for (int i = 0; i < FILL_WORDS; i++) begin
      if (i == 60) hold_req = 1'b1;
      send_word(CMD_ALLOC, random_handle());
    end
    wait_replies();

    // sender mostly idle
    send_idle_pct = 85;
    for (int i = 0; i < PHASE_WORDS; i++) send_random(60);
    wait_replies();

    // receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    for (int i = 0; i < PHASE_WORDS; i++) send_random(40);
    wait_replies();

    // light idling on both sides
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    for (int i = 0; i < PHASE_WORDS; i++) send_random(30);
    wait_replies();

    repeat (20) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== bitmap_handle_allocator_core.f =====
hdl/bha_pkg.sv
hdl/bitmap_handle_allocator_core.sv
verif/bitmap_handle_allocator_core_check.sv
verif/bitmap_handle_allocator_core_tb.sv
